// ----- hw/rtl/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define CHK_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`endif

// ----- hw/rtl/lrrc_pkg.sv -----
package lrrc_pkg;
  localparam int DefByteCountBits = 48;
  localparam int DefRecordCountBits = 32;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] AllOnes32 = 32'hFFFFFFFF;
  localparam logic [4:0] HdrLast = 5'd20;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindAccept = 2'd1;
  localparam logic [1:0] KindReject = 2'd2;
  localparam logic [1:0] KindSummary = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload_byte;
    logic               payload_is_value;
    logic [7:0]         op_code;
    logic signed [63:0] stamp_ms;
    logic [31:0]        key_length;
    logic [31:0]        value_length;
    logic [31:0]        records_count;
    logic [47:0]        accepted_bytes;
    logic               truncated;
    logic               last_of_run;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic       eol;
    logic       hdr;
    logic [4:0] idx;
    logic       is_value;
    logic       rec_end;
    logic [7:0] data;
  } work_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? (CrcPoly ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction
endpackage

// ----- hw/rtl/lrrc_fifo.sv -----
module lrrc_fifo import lrrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  work_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output work_t rd_data
);
  work_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data;
        wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ----- hw/rtl/lrrc_front.sv -----
module lrrc_front import lrrc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     wk_valid,
  input  logic     wk_ready,
  output work_t    wk_data
);
  // front tracks header and payload position of every transfer
  logic [4:0]  header_index;
  logic        in_payload;
  logic [31:0] key_len, value_len;
  logic [32:0] payload_left;
  logic [32:0] body_len;
  logic        last_hdr;

  assign in_ready = wk_ready;
  assign wk_valid = in_valid;
  assign last_hdr = !in_payload && (header_index == HdrLast);
  assign body_len = {1'b0, key_len} + {1'b0, in_item.data_byte, value_len[23:0]};

  always_comb begin
    wk_data.eol = in_item.req_type;
    wk_data.hdr = !in_payload;
    wk_data.idx = header_index;
    wk_data.is_value = (payload_left <= {1'b0, value_len});
    wk_data.rec_end = in_payload ? (payload_left == 33'd1) : (last_hdr && (body_len == 33'd0));
    wk_data.data = in_item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index <= '0;
      in_payload <= 1'b0;
      key_len <= '0;
      value_len <= '0;
      payload_left <= '0;
    end else if (in_valid && in_ready) begin
      if (in_item.req_type) begin
        header_index <= '0;
        in_payload <= 1'b0;
        payload_left <= '0;
      end else if (in_payload) begin
        payload_left <= payload_left - 33'd1;
        if (payload_left == 33'd1) in_payload <= 1'b0;
      end else begin
        if (header_index >= 5'd13 && header_index <= 5'd16)
          key_len[8*(header_index - 5'd13) +: 8] <= in_item.data_byte;
        if (header_index >= 5'd17)
          value_len[8*(header_index - 5'd17) +: 8] <= in_item.data_byte;
        if (last_hdr) begin
          header_index <= '0;
          payload_left <= body_len;
          in_payload <= (body_len != 33'd0);
        end else begin
          header_index <= header_index + 5'd1;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/lrrc_back.sv -----
module lrrc_back import lrrc_pkg::*; #(
  parameter int BYTE_COUNT_BITS = DefByteCountBits,
  parameter int RECORD_COUNT_BITS = DefRecordCountBits
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] max_op,
  input  logic       wk_valid,
  output logic       wk_ready,
  input  work_t      wk_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);
  localparam logic [BYTE_COUNT_BITS-1:0] ByteMax = '1;
  localparam logic [RECORD_COUNT_BITS-1:0] RecMax = '1;

  logic [31:0] stored_check, running_check, key_len_reg, value_len_reg;
  logic [63:0] stamp_reg;
  logic [7:0]  op_reg;
  logic [RECORD_COUNT_BITS-1:0] accepted_count;
  logic [BYTE_COUNT_BITS-1:0]   good_byte_count, total_byte_count;
  logic stopped;

  logic [31:0] stored_check_next, running_check_next, key_len_reg_next, value_len_reg_next;
  logic [63:0] stamp_reg_next;
  logic [7:0]  op_reg_next;
  logic [RECORD_COUNT_BITS-1:0] accepted_count_next;
  logic [BYTE_COUNT_BITS-1:0]   good_byte_count_next, total_byte_count_next;
  logic stopped_next;

  // two output slots: primary and a held verdict
  logic      o_valid, v_valid, o_valid_next, v_valid_next;
  out_item_t v_item, out_item_next, v_item_next;

  logic [31:0] crc_new, vl_new;
  logic [33:0] rec_len;
  logic [BYTE_COUNT_BITS:0] good_sum;
  logic fire, last_hdr, ok_now;

  function automatic out_item_t verdict(logic ok, logic [7:0] op, logic [63:0] st,
                                        logic [31:0] kl, logic [31:0] vl);
    out_item_t r;
    r = '0;
    r.kind = ok ? KindAccept : KindReject;
    r.op_code = op;
    r.stamp_ms = st;
    r.key_length = kl;
    r.value_length = vl;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  assign out_valid = o_valid;
  assign wk_ready = !v_valid && (!o_valid || out_ready);
  assign fire = wk_valid && wk_ready;
  assign crc_new = crc_byte(running_check, wk_data.data);
  assign last_hdr = wk_data.hdr && (wk_data.idx == HdrLast);
  assign vl_new = last_hdr ? {wk_data.data, value_len_reg[23:0]} : value_len_reg;
  assign ok_now = ((crc_new ^ AllOnes32) == stored_check) && (op_reg <= max_op);
  assign rec_len = 34'd21 + {2'b0, key_len_reg} + {2'b0, vl_new};
  assign good_sum = {1'b0, good_byte_count} + (BYTE_COUNT_BITS + 1)'(rec_len);

  always_comb begin
    stored_check_next = stored_check;
    running_check_next = running_check;
    key_len_reg_next = key_len_reg;
    value_len_reg_next = value_len_reg;
    stamp_reg_next = stamp_reg;
    op_reg_next = op_reg;
    accepted_count_next = accepted_count;
    good_byte_count_next = good_byte_count;
    total_byte_count_next = total_byte_count;
    stopped_next = stopped;
    o_valid_next = o_valid;
    out_item_next = out_item;
    v_valid_next = v_valid;
    v_item_next = v_item;
    if (o_valid && out_ready) begin
      o_valid_next = v_valid;
      out_item_next = v_item;
      v_valid_next = 1'b0;
    end
    if (fire) begin
      if (wk_data.eol) begin
        o_valid_next = 1'b1;
        out_item_next = '0;
        out_item_next.kind = KindSummary;
        out_item_next.records_count = 32'(accepted_count);
        out_item_next.accepted_bytes = 48'(good_byte_count);
        out_item_next.truncated = (!wk_data.hdr) || (wk_data.idx != 5'd0) || stopped;
        out_item_next.last_of_run = 1'b1;
        stored_check_next = '0;
        running_check_next = AllOnes32;
        key_len_reg_next = '0;
        value_len_reg_next = '0;
        stamp_reg_next = '0;
        op_reg_next = '0;
        accepted_count_next = '0;
        good_byte_count_next = '0;
        total_byte_count_next = '0;
        stopped_next = 1'b0;
      end else begin
        if (total_byte_count != ByteMax)
          total_byte_count_next = total_byte_count + BYTE_COUNT_BITS'(1);
        if (!stopped) begin
          if (!wk_data.hdr) begin
            running_check_next = crc_new;
            o_valid_next = 1'b1;
            out_item_next = '0;
            out_item_next.kind = KindPayload;
            out_item_next.payload_byte = wk_data.data;
            out_item_next.payload_is_value = wk_data.is_value;
            out_item_next.last_of_run = !wk_data.rec_end;
          end else begin
            unique case (wk_data.idx)
              5'd0: begin
                stored_check_next = {24'd0, wk_data.data};
                stamp_reg_next = '0;
                op_reg_next = '0;
                key_len_reg_next = '0;
                value_len_reg_next = '0;
                running_check_next = AllOnes32;
              end
              5'd1, 5'd2, 5'd3:
                stored_check_next[8*wk_data.idx[1:0] +: 8] = wk_data.data;
              5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11:
                stamp_reg_next[8*(wk_data.idx - 5'd4) +: 8] = wk_data.data;
              5'd12: op_reg_next = wk_data.data;
              5'd13, 5'd14, 5'd15, 5'd16:
                key_len_reg_next[8*(wk_data.idx - 5'd13) +: 8] = wk_data.data;
              default:
                value_len_reg_next[8*(wk_data.idx - 5'd17) +: 8] = wk_data.data;
            endcase
            if (wk_data.idx >= 5'd4) running_check_next = crc_new;
          end
          if (wk_data.rec_end) begin
            running_check_next = AllOnes32;
            if (ok_now) begin
              if (accepted_count != RecMax)
                accepted_count_next = accepted_count + RECORD_COUNT_BITS'(1);
              good_byte_count_next = good_sum[BYTE_COUNT_BITS] ? ByteMax :
                                     good_sum[BYTE_COUNT_BITS-1:0];
            end else begin
              stopped_next = 1'b1;
            end
            if (wk_data.hdr) begin
              o_valid_next = 1'b1;
              out_item_next = verdict(ok_now, op_reg, stamp_reg, key_len_reg, vl_new);
            end else begin
              v_valid_next = 1'b1;
              v_item_next = verdict(ok_now, op_reg, stamp_reg, key_len_reg, vl_new);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      v_valid <= 1'b0;
      out_item <= '0;
      v_item <= '0;
      stored_check <= '0;
      running_check <= AllOnes32;
      key_len_reg <= '0;
      value_len_reg <= '0;
      stamp_reg <= '0;
      op_reg <= '0;
      accepted_count <= '0;
      good_byte_count <= '0;
      total_byte_count <= '0;
      stopped <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
      v_valid <= v_valid_next;
      out_item <= out_item_next;
      v_item <= v_item_next;
      stored_check <= stored_check_next;
      running_check <= running_check_next;
      key_len_reg <= key_len_reg_next;
      value_len_reg <= value_len_reg_next;
      stamp_reg <= stamp_reg_next;
      op_reg <= op_reg_next;
      accepted_count <= accepted_count_next;
      good_byte_count <= good_byte_count_next;
      total_byte_count <= total_byte_count_next;
      stopped <= stopped_next;
    end
  end
endmodule

// ----- hw/rtl/log_record_replay_checker_core.sv -----
// Write-ahead log record checker. Takes one log byte per cycle (or an end-of-log
// request) on in_valid/in_ready unless held by back-pressure, and emits payload
// bytes, record verdicts and an end-of-log summary on out_valid/out_ready. A front
// stage tracks the header and payload position and a two-entry queue feeds the
// back stage, which runs a byte-wide CRC-32 and the header capture, so the first
// result of a transfer is registered in the queue and then in the back stage's
// output slot. Items flow at one per cycle while out_ready stays high, except
// that a payload byte that ends a record gives two results and holds the back
// stage while the verdict drains. max_op is written through cfg_valid/cfg_ready.
module log_record_replay_checker_core import lrrc_pkg::*; #(
  parameter int BYTE_COUNT_BITS = DefByteCountBits,
  parameter int RECORD_COUNT_BITS = DefRecordCountBits
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  logic [7:0] max_op;
  logic f_valid, f_ready, q_valid, q_ready;
  work_t f_data, q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_op <= 8'd1;
    else if (cfg_valid) max_op <= cfg_data;
  end

  lrrc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .wk_valid(f_valid), .wk_ready(f_ready), .wk_data(f_data)
  );

  lrrc_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  lrrc_back #(
    .BYTE_COUNT_BITS(BYTE_COUNT_BITS), .RECORD_COUNT_BITS(RECORD_COUNT_BITS)
  ) u_back (
    .clk, .rst, .max_op, .wk_valid(q_valid), .wk_ready(q_ready), .wk_data(q_data),
    .out_valid, .out_ready, .out_item
  );
endmodule

// ----- hw/rtl/lrrc_checker.sv -----
`include "assert_macros.svh"
module lrrc_checker import lrrc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);
  `CHK_NEXT(out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
  `CHK_IMPLIES(sum_last, out_valid && out_item.kind == KindSummary, out_item.last_of_run)
  `CHK_IMPLIES(verdict_last, out_valid && (out_item.kind == KindAccept ||
               out_item.kind == KindReject), out_item.last_of_run)
  `CHK_IMPLIES(pay_clean, out_valid && out_item.kind == KindPayload,
               out_item.records_count == 32'd0 && out_item.op_code == 8'd0)
endmodule

bind log_record_replay_checker_core lrrc_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_item
);

// ----- test/log_record_replay_checker_core_tb.sv -----
module log_record_replay_checker_core_tb;
  import lrrc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  log_record_replay_checker_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  localparam int WatchLimit = 20000;

  // log checker predictor state
  logic [7:0]  lim_op;
  logic [4:0]  hdr_pos;
  logic        in_body;
  logic [31:0] want_crc;
  logic [63:0] stamp_q;
  logic [7:0]  op_q;
  logic [31:0] klen_q, vlen_q;
  logic [32:0] body_left;
  logic [31:0] crc_q;
  logic [31:0] rec_cnt;
  logic [47:0] good_cnt;
  logic        halted;

  in_item_t  log_queue[$];
  out_item_t expected_out[$];
  int sender_idle = 0, receiver_idle = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_send = 1'b0;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = r[0] ? (32'hEDB88320 ^ (r >> 1)) : (r >> 1);
    return r;
  endfunction

  task automatic clear_log();
    hdr_pos = 0; in_body = 0; want_crc = 0; stamp_q = 0; op_q = 0;
    klen_q = 0; vlen_q = 0; body_left = 0; crc_q = '1;
    rec_cnt = 0; good_cnt = 0; halted = 0;
  endtask

  function automatic out_item_t close_record();
    out_item_t r;
    logic ok;
    logic [47:0] add;
    r = '0;
    ok = ((crc_q ^ 32'hFFFFFFFF) == want_crc) && (op_q <= lim_op);
    r.kind = ok ? KindAccept : KindReject;
    r.op_code = op_q; r.stamp_ms = stamp_q; r.key_length = klen_q; r.value_length = vlen_q;
    if (ok) begin
      if (rec_cnt != '1) rec_cnt = rec_cnt + 1;
      add = 48'd21 + klen_q + vlen_q;
      good_cnt = (good_cnt > ~add) ? '1 : good_cnt + add;
    end else begin
      halted = 1;
    end
    hdr_pos = 0; in_body = 0; body_left = 0; crc_q = '1;
    return r;
  endfunction

  task automatic predict_log(in_item_t it);
    out_item_t r[2];
    int n;
    logic [7:0] b;
    n = 0; r[0] = '0; r[1] = '0; b = it.data_byte;
    if (it.req_type) begin
      r[0].kind = KindSummary; r[0].records_count = rec_cnt; r[0].accepted_bytes = good_cnt;
      r[0].truncated = (hdr_pos != 0) || in_body || halted;
      n = 1;
      clear_log();
    end else if (!halted) begin
      if (in_body) begin
        crc_q = crc_step(crc_q, b);
        r[0].kind = KindPayload; r[0].payload_byte = b;
        r[0].payload_is_value = body_left <= {1'b0, vlen_q};
        n = 1;
        body_left = body_left - 1;
        if (body_left == 0) begin r[1] = close_record(); n = 2; end
      end else begin
        if (hdr_pos == 0) begin
          want_crc = 0; stamp_q = 0; op_q = 0; klen_q = 0; vlen_q = 0; crc_q = '1;
        end
        if (hdr_pos >= 4) crc_q = crc_step(crc_q, b);
        if (hdr_pos < 4) want_crc[8*hdr_pos +: 8] = b;
        else if (hdr_pos < 12) stamp_q[8*(hdr_pos-4) +: 8] = b;
        else if (hdr_pos == 12) op_q = b;
        else if (hdr_pos < 17) klen_q[8*(hdr_pos-13) +: 8] = b;
        else vlen_q[8*(hdr_pos-17) +: 8] = b;
        if (hdr_pos == HdrLast) begin
          hdr_pos = 0;
          body_left = {1'b0, klen_q} + vlen_q;
          if (body_left == 0) begin r[0] = close_record(); n = 1; end
          else in_body = 1;
        end else begin
          hdr_pos = hdr_pos + 1;
        end
      end
    end
    if (n > 0) r[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) expected_out.insert(expected_out.size(), r[k]);
  endtask

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it.req_type = 1'b0; it.data_byte = b;
    log_queue.insert(log_queue.size(), it);
  endtask

  task automatic push_eol();
    in_item_t it;
    it.req_type = 1'b1; it.data_byte = 8'($urandom);
    log_queue.insert(log_queue.size(), it);
  endtask

  // builds one record; corrupt flips one crc bit
  task automatic push_record(logic [7:0] op, logic [63:0] st, int klen, int vlen,
                             bit corrupt, int cut);
    logic [7:0] body[$];
    logic [31:0] c;
    int emitted;
    c = '1;
    for (int i = 0; i < 8; i++) body.insert(body.size(), st[8*i +: 8]);
    body.insert(body.size(), op);
    for (int i = 0; i < 4; i++) body.insert(body.size(), 8'(klen >> (8*i)));
    for (int i = 0; i < 4; i++) body.insert(body.size(), 8'(vlen >> (8*i)));
    for (int i = 0; i < klen + vlen; i++) body.insert(body.size(), 8'($urandom));
    foreach (body[i]) c = crc_step(c, body[i]);
    c = c ^ 32'hFFFFFFFF;
    if (corrupt) c[$urandom_range(31, 0)] ^= 1'b1;
    emitted = 0;
    for (int i = 0; i < 4; i++) begin
      if (cut >= 0 && emitted >= cut) return;
      push_byte(c[8*i +: 8]); emitted++;
    end
    foreach (body[i]) begin
      if (cut >= 0 && emitted >= cut) return;
      push_byte(body[i]); emitted++;
    end
  endtask

  task automatic wait_drained();
    while (log_queue.size() != 0 || in_valid || expected_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_max_op(logic [7:0] v);
    cfg_valid <= 1'b1; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lim_op = v;
  endtask

  task automatic random_phase(int items);
    int start;
    start = log_queue.size();
    while (log_queue.size() - start < items) begin
      case ($urandom_range(9, 0))
        0: push_eol();
        1: push_byte(8'($urandom));
        2: push_record(8'($urandom), {$urandom, $urandom}, $urandom_range(3, 0),
                       $urandom_range(3, 0), 1'b0, $urandom_range(20, 0));
        3: push_record(8'($urandom_range(lim_op, 0)), {$urandom, $urandom},
                       $urandom_range(4, 0), $urandom_range(4, 0), 1'b1, -1);
        default: push_record(8'($urandom_range(lim_op, 0)), {$urandom, $urandom},
                             $urandom_range(5, 0), $urandom_range(5, 0), 1'b0, -1);
      endcase
    end
    push_eol();
  endtask

  initial forever #5 clk = ~clk;

  initial begin
    lim_op = 8'd1;
    clear_log();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty record, payload records, bad op, bad crc, eol cases
    push_eol();
    push_record(8'd1, 64'h8000_0000_0000_0000, 0, 0, 1'b0, -1);
    push_record(8'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 2, 1'b0, -1);
    push_eol();
    push_record(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1'b0, 7);
    push_eol();
    push_record(8'd2, 64'd5, 0, 1, 1'b0, -1);
    push_byte(8'hFF);
    push_eol();
    wait_drained();
    push_record(8'd0, 64'd1, 1, 0, 1'b1, -1);
    push_byte(8'h00);
    push_eol();
    wait_drained();
    write_max_op(8'd255);
    push_record(8'hFF, 64'd0, 0, 0, 1'b0, -1);
    push_eol();
    wait_drained();
    sender_idle = 30; receiver_idle = 83;
    random_phase(90);
    wait_drained();
    write_max_op(8'd0);
    sender_idle = 83; receiver_idle = 30;
    random_phase(50);
    while (log_queue.size() != 0) @(posedge clk);
    // hold off the sender until all results are back
    hold_send = 1'b1;
    while (expected_out.size() != 0 || in_valid) @(posedge clk);
    hold_send = 1'b0;
    random_phase(40);
    wait_drained();
    write_max_op(8'd7);
    sender_idle = 0; receiver_idle = 0;
    random_phase(90);
    wait_drained();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (log_queue.size() != 0 && !hold_send && $urandom_range(99, 0) >= sender_idle)
        begin
          in_item <= log_queue[0];
          predict_log(log_queue.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(99, 0) >= receiver_idle;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = expected_out.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
